/* hdl/rss_pkg.sv */
// Shared types, constants and codes for the RAID0 stripe request splitter.
`timescale 1ns / 1ps

package rss_pkg;

	localparam int RSS_ADDR_BITS         = 48;
	localparam int RSS_KIB_SHIFT         = 10;
	localparam int RSS_OBJ_BITS          = RSS_ADDR_BITS - RSS_KIB_SHIFT;
	localparam int RSS_KIB_BITS          = 16;
	localparam int RSS_OFF_BITS          = RSS_KIB_BITS + RSS_KIB_SHIFT;
	localparam int RSS_LEN_BITS          = 16;
	localparam int RSS_POS_BITS          = 15;
	localparam int RSS_MAX_REQUEST_BYTES = 32768;
	localparam int RSS_MAX_REPLICAS      = 4;
	localparam int RSS_TARGETS           = 4;
	localparam int RSS_REP_LIMIT         =
		(RSS_MAX_REPLICAS < RSS_TARGETS) ? RSS_MAX_REPLICAS : RSS_TARGETS;
	localparam int RSS_REP_BITS          = 3;
	localparam int RSS_TGT_BITS          = 8;
	localparam int RSS_WIDTH_BITS        = RSS_TGT_BITS + 1;
	localparam int RSS_MAX_WIDTH         = 256;
	localparam int RSS_CNT_BITS          = $clog2(RSS_OBJ_BITS);
	localparam int RSS_CFG_IDX_BITS      = 3;
	localparam int RSS_CFG_DATA_BITS     = 16;

	localparam logic [RSS_KIB_BITS-1:0]   RSS_STRIPE_RESET = 16'd128;
	localparam logic [RSS_REP_BITS-1:0]   RSS_COUNT_RESET  = 3'd1;
	localparam logic [RSS_WIDTH_BITS-1:0] RSS_WIDTH_RESET  = 9'd1;

	typedef enum logic [RSS_CFG_IDX_BITS-1:0] {
		CFG_STRIPE_KIB    = 3'd0,
		CFG_REPLICA_COUNT = 3'd1,
		CFG_WIDTH_0       = 3'd2,
		CFG_WIDTH_1       = 3'd3,
		CFG_WIDTH_2       = 3'd4,
		CFG_WIDTH_3       = 3'd5
	} rss_cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} rss_state_t;

	typedef struct packed {
		logic                     func;
		logic [RSS_ADDR_BITS-1:0] request_offset;
		logic [RSS_LEN_BITS-1:0]  request_length;
	} rss_req_t;

	typedef struct packed {
		logic                     op_kind;
		logic [RSS_OBJ_BITS-1:0]  object_number;
		logic [RSS_OFF_BITS-1:0]  chunk_offset;
		logic [RSS_LEN_BITS-1:0]  chunk_length;
		logic [RSS_POS_BITS-1:0]  buffer_position;
		logic [RSS_TGT_BITS-1:0]  target_0;
		logic [RSS_TGT_BITS-1:0]  target_1;
		logic [RSS_TGT_BITS-1:0]  target_2;
		logic [RSS_TGT_BITS-1:0]  target_3;
		logic                     last_chunk;
	} rss_chunk_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic incr;
	} rss_div_ctrl_t;

	typedef struct packed {
		logic clear;
		logic shift;
		logic qbit;
		logic incr;
	} rss_mod_ctrl_t;

endpackage

/* hdl/rss_divider.sv */
// Bit-serial restoring divider of the object address by the stripe size in KiB.
`timescale 1ns / 1ps

module rss_divider import rss_pkg::*; (
	input  logic                    clk,
	input  rss_div_ctrl_t           ctrl,
	input  logic [RSS_OBJ_BITS-1:0] dividend,
	input  logic [RSS_KIB_BITS-1:0] divisor,
	output logic                    qbit,
	output logic [RSS_OBJ_BITS-1:0] quo,
	output logic [RSS_KIB_BITS-1:0] rem
);

	logic [RSS_OBJ_BITS-1:0] quo_q;
	logic [RSS_KIB_BITS-1:0] rem_q;
	logic [RSS_KIB_BITS:0]   trial;
	logic [RSS_KIB_BITS:0]   diff;

	assign trial = {rem_q, quo_q[RSS_OBJ_BITS-1]};
	assign diff  = trial - {1'b0, divisor};
	assign qbit  = (trial >= {1'b0, divisor});
	assign quo   = quo_q;
	assign rem   = rem_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (ctrl.shift) begin
			quo_q <= {quo_q[RSS_OBJ_BITS-2:0], qbit};
			rem_q <= qbit ? diff[RSS_KIB_BITS-1:0] : trial[RSS_KIB_BITS-1:0];
		end else if (ctrl.incr) begin
			quo_q <= quo_q + RSS_OBJ_BITS'(1);
			rem_q <= '0;
		end
	end

endmodule

/* hdl/rss_tgt_mod.sv */
// Bit-serial residue of the object number modulo one replica's stripe width.
`timescale 1ns / 1ps

module rss_tgt_mod import rss_pkg::*; (
	input  logic                      clk,
	input  rss_mod_ctrl_t             ctrl,
	input  logic [RSS_WIDTH_BITS-1:0] width,
	output logic [RSS_TGT_BITS-1:0]   residue
);

	logic [RSS_TGT_BITS-1:0]   res_q;
	logic [RSS_WIDTH_BITS-1:0] dbl;
	logic [RSS_WIDTH_BITS-1:0] dbl_sub;
	logic [RSS_WIDTH_BITS-1:0] inc;

	assign dbl     = {res_q, ctrl.qbit};
	assign dbl_sub = dbl - width;
	assign inc     = {1'b0, res_q} + RSS_WIDTH_BITS'(1);
	assign residue = res_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			res_q <= '0;
		end else if (ctrl.shift) begin
			res_q <= (dbl >= width) ? dbl_sub[RSS_TGT_BITS-1:0] : dbl[RSS_TGT_BITS-1:0];
		end else if (ctrl.incr) begin
			res_q <= (inc == width) ? '0 : inc[RSS_TGT_BITS-1:0];
		end
	end

endmodule

/* hdl/raid0_stripe_request_splitter.sv */
// Top level: splits a byte request into stripe chunks with per-replica targets.
//
//   channel  direction  handshake              beat
//   req      in         req_valid / req_stall  rss_req_t: func, offset, length
//   chunk    out        chunk_valid / stall    rss_chunk_t: one stripe chunk
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request is accepted in idle, divided in the serial divider, then gives one
// chunk per cycle while chunk_stall is low; a run that wraps past the top of the
// address range pays a second division. A zero-length request makes no chunk.
// Reset loads the configuration defaults and empties the output register.
// chunk_stall holds the output register and the sequencer behind it.
`timescale 1ns / 1ps

module raid0_stripe_request_splitter import rss_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  rss_req_t                     req,
	output logic                         chunk_valid,
	input  logic                         chunk_stall,
	output rss_chunk_t                   chunk,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [RSS_CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [RSS_CFG_DATA_BITS-1:0] cfg_data
);

	rss_state_t state_q, state_d;

	logic [RSS_KIB_BITS-1:0]   stripe_kib_q;
	logic [RSS_REP_BITS-1:0]   replica_count_q;
	logic [RSS_WIDTH_BITS-1:0] width_q [RSS_TARGETS];

	logic [RSS_KIB_BITS-1:0]   stripe_eff;
	logic [RSS_REP_BITS-1:0]   reps;
	logic [RSS_WIDTH_BITS-1:0] width_eff [RSS_TARGETS];
	logic [RSS_TGT_BITS-1:0]   residue [RSS_TARGETS];
	logic [RSS_TGT_BITS-1:0]   tgt_eff [RSS_TARGETS];

	logic                      kind_q;
	logic [RSS_ADDR_BITS-1:0]  addr_q;
	logic [RSS_LEN_BITS-1:0]   len_q;
	logic [RSS_LEN_BITS-1:0]   pos_q;
	logic [RSS_CNT_BITS-1:0]   cnt_q;
	rss_chunk_t                out_q;
	logic                      out_valid_q;

	logic [RSS_LEN_BITS-1:0]   req_len_sat;
	logic [RSS_OFF_BITS-1:0]   off;
	logic [RSS_OFF_BITS-1:0]   stripe_bytes;
	logic [RSS_OFF_BITS-1:0]   room;
	logic [RSS_LEN_BITS-1:0]   left;
	logic                      take_left;
	logic [RSS_LEN_BITS-1:0]   clen;
	logic [RSS_LEN_BITS-1:0]   next_pos;
	logic [RSS_ADDR_BITS:0]    next_addr;
	logic                      wrap;
	logic                      out_free;
	logic                      emit;
	logic                      div_done;

	rss_div_ctrl_t             div_ctrl;
	rss_mod_ctrl_t             mod_ctrl;
	logic [RSS_OBJ_BITS-1:0]   dividend;
	logic                      div_qbit;
	logic [RSS_OBJ_BITS-1:0]   div_quo;
	logic [RSS_KIB_BITS-1:0]   div_rem;
	rss_chunk_t                out_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stripe_kib_q    <= RSS_STRIPE_RESET;
			replica_count_q <= RSS_COUNT_RESET;
			for (int i = 0; i < RSS_TARGETS; i++) begin
				width_q[i] <= RSS_WIDTH_RESET;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index) inside
				CFG_STRIPE_KIB: begin
					stripe_kib_q <= cfg_data[RSS_KIB_BITS-1:0];
				end
				CFG_REPLICA_COUNT: begin
					replica_count_q <= cfg_data[RSS_REP_BITS-1:0];
				end
				[CFG_WIDTH_0:CFG_WIDTH_3]: begin
					width_q[2'(cfg_index - CFG_WIDTH_0)] <= cfg_data[RSS_WIDTH_BITS-1:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		stripe_eff = (stripe_kib_q == '0) ? RSS_KIB_BITS'(1) : stripe_kib_q;
		if (replica_count_q == '0) begin
			reps = RSS_REP_BITS'(1);
		end else if (replica_count_q > RSS_REP_BITS'(RSS_REP_LIMIT)) begin
			reps = RSS_REP_BITS'(RSS_REP_LIMIT);
		end else begin
			reps = replica_count_q;
		end
		for (int i = 0; i < RSS_TARGETS; i++) begin
			if (width_q[i] == '0) begin
				width_eff[i] = RSS_WIDTH_BITS'(1);
			end else if (width_q[i] > RSS_WIDTH_BITS'(RSS_MAX_WIDTH)) begin
				width_eff[i] = RSS_WIDTH_BITS'(RSS_MAX_WIDTH);
			end else begin
				width_eff[i] = width_q[i];
			end
			tgt_eff[i] = (i < int'(reps)) ? residue[i] : '0;
		end
	end

	assign req_len_sat = (req.request_length > RSS_LEN_BITS'(RSS_MAX_REQUEST_BYTES))
		? RSS_LEN_BITS'(RSS_MAX_REQUEST_BYTES) : req.request_length;

	assign off          = {div_rem, addr_q[RSS_KIB_SHIFT-1:0]};
	assign stripe_bytes = {stripe_eff, {RSS_KIB_SHIFT{1'b0}}};
	assign room         = stripe_bytes - off;
	assign left         = len_q - pos_q;
	assign take_left    = ({{(RSS_OFF_BITS-RSS_LEN_BITS){1'b0}}, left} <= room);
	assign clen         = take_left ? left : room[RSS_LEN_BITS-1:0];
	assign next_pos     = pos_q + clen;
	assign next_addr    = {1'b0, addr_q} + (RSS_ADDR_BITS+1)'(clen);
	assign wrap         = next_addr[RSS_ADDR_BITS];
	assign out_free     = !out_valid_q || !chunk_stall;
	assign div_done     = (cnt_q == RSS_CNT_BITS'(RSS_OBJ_BITS-1));

	assign dividend = (state_q == ST_IDLE) ? req.request_offset[RSS_ADDR_BITS-1:RSS_KIB_SHIFT]
		: next_addr[RSS_ADDR_BITS-1:RSS_KIB_SHIFT];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && (req.request_length != '0)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					if (take_left) begin
						state_d = ST_IDLE;
					end else if (wrap) begin
						state_d = ST_DIV;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		div_ctrl  = '0;
		emit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall     = 1'b0;
				div_ctrl.load = req_valid && (req.request_length != '0);
			end
			ST_DIV: begin
				div_ctrl.shift = 1'b1;
			end
			ST_EMIT: begin
				emit          = out_free;
				div_ctrl.load = out_free && !take_left && wrap;
				div_ctrl.incr = out_free && !take_left && !wrap;
			end
			default: ;
		endcase
	end

	assign mod_ctrl.clear = div_ctrl.load;
	assign mod_ctrl.shift = div_ctrl.shift;
	assign mod_ctrl.qbit  = div_qbit;
	assign mod_ctrl.incr  = div_ctrl.incr;

	rss_divider u_div (
		.clk      (clk),
		.ctrl     (div_ctrl),
		.dividend (dividend),
		.divisor  (stripe_eff),
		.qbit     (div_qbit),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	for (genvar g = 0; g < RSS_TARGETS; g++) begin : g_tgt
		rss_tgt_mod u_mod (
			.clk     (clk),
			.ctrl    (mod_ctrl),
			.width   (width_eff[g]),
			.residue (residue[g])
		);
	end

	always_comb begin
		out_d.op_kind         = kind_q;
		out_d.object_number   = div_quo;
		out_d.chunk_offset    = off;
		out_d.chunk_length    = clen;
		out_d.buffer_position = pos_q[RSS_POS_BITS-1:0];
		out_d.target_0        = tgt_eff[0];
		out_d.target_1        = tgt_eff[1];
		out_d.target_2        = tgt_eff[2];
		out_d.target_3        = tgt_eff[3];
		out_d.last_chunk      = take_left;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_ctrl.load) begin
				cnt_q <= '0;
			end else if (div_ctrl.shift) begin
				cnt_q <= cnt_q + RSS_CNT_BITS'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!chunk_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			kind_q <= req.func;
			addr_q <= req.request_offset;
			len_q  <= req_len_sat;
			pos_q  <= '0;
		end
		if (emit) begin
			out_q  <= out_d;
			pos_q  <= next_pos;
			addr_q <= next_addr[RSS_ADDR_BITS-1:0];
		end
	end

	assign chunk_valid = out_valid_q;
	assign chunk       = out_q;

endmodule

/* hdl/rss_checker.sv */
// Port-level checks on the stripe request splitter, bound to the top level.
`timescale 1ns / 1ps

module rss_checker import rss_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_stall,
	input logic       chunk_valid,
	input logic       chunk_stall,
	input rss_chunk_t chunk
);

	logic                    have_prev_q;
	logic                    prev_last_q;
	logic [RSS_LEN_BITS-1:0] prev_end_q;
	logic                    chunk_beat;

	assign chunk_beat = chunk_valid && !chunk_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_last_q <= 1'b1;
			prev_end_q  <= '0;
		end else if (chunk_beat) begin
			have_prev_q <= 1'b1;
			prev_last_q <= chunk.last_chunk;
			prev_end_q  <= {1'b0, chunk.buffer_position} + chunk.chunk_length;
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_valid && chunk_stall |=> chunk_valid && $stable(chunk))
		else $error("stalled chunk beat changed");

	a_busy_mid_request: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_valid && !chunk.last_chunk |-> req_stall)
		else $error("request taken before the previous one finished");

	a_position_follows: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_beat && have_prev_q && !prev_last_q
		|-> chunk.buffer_position == prev_end_q[RSS_POS_BITS-1:0])
		else $error("chunk buffer position does not follow the previous chunk");

	a_length_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_valid |-> chunk.chunk_length != '0)
		else $error("empty chunk emitted");

endmodule

bind raid0_stripe_request_splitter rss_checker u_rss_checker (.*);
